// File: hw/rtl/apsp_pkg.sv
// Shared constants, command/status structs and cost arithmetic for the shortest path router.
`timescale 1ns / 1ps
package apsp_pkg;

  localparam int MAX_NODES = 8;
  localparam int COST_W    = 16;
  localparam int NODE_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int ADDR_W    = 2 * NODE_W;
  localparam int DEPTH     = MAX_NODES * MAX_NODES;
  localparam int CFG_W     = 4;

  localparam logic [COST_W-1:0] COST_MAX   = {COST_W{1'b1}};
  localparam logic [CFG_W-1:0]  NODE_RESET = CFG_W'(8);

  // Controller to datapath
  typedef struct packed {
    logic load_wr;   // write the incoming cost and advance the load position
    logic clr_cnt;   // zero the relaxation counters
    logic row_rd;    // read d[i][k] and h[i][k]
    logic row_cap;   // capture d[i][k] and h[i][k]
    logic relax_rd;  // issue reads for one (i,j) relaxation and advance
    logic emit_cap;  // load the output register and advance
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic load_last;
    logic i_last;
    logic j_last;
    logic k_last;
    logic out_free;
  } sts_t;

  // Saturating add: unreachable in, or overflow, gives unreachable.
  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (a == COST_MAX || b == COST_MAX || s[COST_W]) begin
      return COST_MAX;
    end
    return s[COST_W-1:0];
  endfunction

endpackage

// File: hw/rtl/apsp_ram.sv
// Generic single write port, single registered read port RAM.
`timescale 1ns / 1ps
module apsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/apsp_ctrl.sv
// Sequencer for load, relaxation and table emit phases.
`timescale 1ns / 1ps
module apsp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  apsp_pkg::sts_t sts_i,
  output apsp_pkg::cmd_t cmd_o
);
  import apsp_pkg::*;

  typedef enum logic [2:0] {
    LOAD,
    ROW_RD,
    ROW_CAP,
    RELAX,
    FLUSH,
    EMIT_RD,
    EMIT_CAP
  } state_e;

  state_e state_q, state_d;
  logic   stall_q, stall_d;
  cmd_t   cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      LOAD: begin
        cmd.load_wr = in_valid_i;
        if (in_valid_i && sts_i.load_last) begin
          cmd.clr_cnt = 1'b1;
          state_d     = ROW_RD;
        end
      end
      ROW_RD: begin
        cmd.row_rd = 1'b1;
        state_d    = ROW_CAP;
      end
      ROW_CAP: begin
        cmd.row_cap = 1'b1;
        state_d     = RELAX;
      end
      RELAX: begin
        cmd.relax_rd = 1'b1;
        if (sts_i.j_last) begin
          state_d = (sts_i.i_last && sts_i.k_last) ? FLUSH : ROW_RD;
        end
      end
      // let the final relaxation write land before the emit reads start
      FLUSH:   state_d = EMIT_RD;
      EMIT_RD: state_d = EMIT_CAP;
      EMIT_CAP: begin
        if (sts_i.out_free) begin
          cmd.emit_cap = 1'b1;
          state_d      = (sts_i.i_last && sts_i.j_last) ? LOAD : EMIT_RD;
        end
      end
      default: state_d = LOAD;
    endcase
    stall_d = (state_d != LOAD);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LOAD;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= stall_d;
    end
  end

  assign in_stall_o = stall_q;
  assign cmd_o      = cmd;

endmodule

// File: hw/rtl/apsp_datapath.sv
// Cost and next-hop tables, loop counters, relaxation unit and output register.
`timescale 1ns / 1ps
module apsp_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [apsp_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic [15:0]                  link_cost_i,
  input  apsp_pkg::cmd_t               cmd_i,
  output apsp_pkg::sts_t               sts_o,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [apsp_pkg::NODE_W-1:0]  source_node_o,
  output logic [apsp_pkg::NODE_W-1:0]  dest_node_o,
  output logic [15:0]                  path_cost_o,
  output logic [apsp_pkg::NODE_W-1:0]  next_hop_o,
  output logic                         last_entry_o
);
  import apsp_pkg::*;

  logic [CFG_W-1:0]  node_q;
  logic [CFG_W-1:0]  n_eff;
  logic [NODE_W-1:0] nlast;

  logic [NODE_W-1:0] ld_row_q, ld_col_q;
  logic [NODE_W-1:0] i_q, j_q, k_q;
  logic              i_last, j_last, k_last, ld_row_last, ld_col_last;

  logic [COST_W-1:0] dik_q;
  logic [NODE_W-1:0] hik_q;
  logic              rel_v_q;
  logic [ADDR_W-1:0] rel_wa_q;

  logic [COST_W-1:0] dist_a, dist_b, via;
  logic [NODE_W-1:0] hop_rd;
  logic              rel_wr;

  logic              we;
  logic [ADDR_W-1:0] waddr, addr_ij, addr_a, addr_b, addr_h;
  logic [COST_W-1:0] wcost;
  logic [NODE_W-1:0] whop;

  logic              out_valid_q;
  logic [NODE_W-1:0] src_q, dst_q, hop_q;
  logic [15:0]       cost_q;
  logic              last_q;

  // clamp the configured count into 1..MAX_NODES
  always_comb begin
    if (node_q == '0) begin
      n_eff = CFG_W'(1);
    end else if (node_q > CFG_W'(MAX_NODES)) begin
      n_eff = CFG_W'(MAX_NODES);
    end else begin
      n_eff = node_q;
    end
    nlast = NODE_W'(n_eff - CFG_W'(1));
  end

  assign i_last      = (i_q == nlast);
  assign j_last      = (j_q == nlast);
  assign k_last      = (k_q == nlast);
  assign ld_row_last = (ld_row_q == nlast);
  assign ld_col_last = (ld_col_q == nlast);

  assign via    = sat_add(dik_q, dist_b);
  assign rel_wr = rel_v_q && (dist_a > via);

  assign addr_ij = {i_q, j_q};
  assign addr_a  = cmd_i.row_rd ? {i_q, k_q} : addr_ij;
  assign addr_h  = addr_a;
  assign addr_b  = {k_q, j_q};

  always_comb begin
    if (cmd_i.load_wr) begin
      we    = 1'b1;
      waddr = {ld_row_q, ld_col_q};
      wcost = COST_W'(link_cost_i);
      whop  = ld_col_q;
    end else begin
      we    = rel_wr;
      waddr = rel_wa_q;
      wcost = via;
      whop  = hik_q;
    end
  end

  // two copies of the distance table give two reads per cycle
  apsp_ram #(.WIDTH(COST_W), .DEPTH(DEPTH)) u_dist_a (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wcost), .raddr_i(addr_a), .rdata_o(dist_a)
  );

  apsp_ram #(.WIDTH(COST_W), .DEPTH(DEPTH)) u_dist_b (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wcost), .raddr_i(addr_b), .rdata_o(dist_b)
  );

  apsp_ram #(.WIDTH(NODE_W), .DEPTH(DEPTH)) u_hop (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(whop), .raddr_i(addr_h), .rdata_o(hop_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q      <= NODE_RESET;
      ld_row_q    <= '0;
      ld_col_q    <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      rel_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        node_q   <= cfg_data_i;
        ld_row_q <= '0;
        ld_col_q <= '0;
      end else if (cmd_i.load_wr) begin
        if (ld_col_last) begin
          ld_col_q <= '0;
          ld_row_q <= ld_row_last ? '0 : ld_row_q + 1'b1;
        end else begin
          ld_col_q <= ld_col_q + 1'b1;
        end
      end

      if (cmd_i.clr_cnt) begin
        i_q <= '0;
        j_q <= '0;
        k_q <= '0;
      end else if (cmd_i.relax_rd || cmd_i.emit_cap) begin
        if (j_last) begin
          j_q <= '0;
          if (i_last) begin
            i_q <= '0;
            // emit leaves k alone; it is already back at zero
            if (cmd_i.relax_rd) begin
              k_q <= k_last ? '0 : k_q + 1'b1;
            end
          end else begin
            i_q <= i_q + 1'b1;
          end
        end else begin
          j_q <= j_q + 1'b1;
        end
      end

      rel_v_q <= cmd_i.relax_rd;

      if (cmd_i.emit_cap) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rel_wa_q <= addr_ij;
    if (cmd_i.row_cap) begin
      dik_q <= dist_a;
      hik_q <= hop_rd;
    end
    if (cmd_i.emit_cap) begin
      src_q  <= i_q;
      dst_q  <= j_q;
      cost_q <= 16'(dist_a);
      hop_q  <= hop_rd;
      last_q <= i_last && j_last;
    end
  end

  assign sts_o.load_last = ld_row_last && ld_col_last;
  assign sts_o.i_last    = i_last;
  assign sts_o.j_last    = j_last;
  assign sts_o.k_last    = k_last;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign source_node_o = src_q;
  assign dest_node_o   = dst_q;
  assign path_cost_o   = cost_q;
  assign next_hop_o    = hop_q;
  assign last_entry_o  = last_q;

endmodule

// File: hw/rtl/all_pairs_shortest_path_router_unit.sv
// Top level of the all-pairs shortest path router: controller plus datapath.
// Usage:
//   cfg_we_i/cfg_data_i set the router count N (0 acts as 1, above 8 as 8);
//   a write restarts matrix loading. Write only while the block is idle.
//   The input channel (in_valid_i/in_stall_o) takes one link cost per
//   transaction, N*N of them in row-major order; all-ones means unreachable.
//   On the last cost the input stalls while the tables are relaxed over
//   every intermediate node, one relaxation per cycle between the row
//   reads of d[i][k], through the single distance write port.
//   The output channel (out_valid_o/out_stall_i) then gives N*N routing
//   entries in row-major order, each read and then captured, with
//   last_entry_o on the final one. A stalled entry holds; emit waits.
//   Loading of the next matrix starts as soon as the final entry sits in
//   the output register.
//   Reset sets N to 8, the load position to zero and empties the output;
//   table contents are not cleared, every entry is written before it is read.
`timescale 1ns / 1ps
module all_pairs_shortest_path_router_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [apsp_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [15:0]                 link_cost_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [apsp_pkg::NODE_W-1:0] source_node_o,
  output logic [apsp_pkg::NODE_W-1:0] dest_node_o,
  output logic [15:0]                 path_cost_o,
  output logic [apsp_pkg::NODE_W-1:0] next_hop_o,
  output logic                        last_entry_o
);
  import apsp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  apsp_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  apsp_datapath u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_data_i,
    .link_cost_i,
    .cmd_i (cmd),
    .sts_o (sts),
    .out_stall_i,
    .out_valid_o,
    .source_node_o,
    .dest_node_o,
    .path_cost_o,
    .next_hop_o,
    .last_entry_o
  );

endmodule

// File: hw/rtl/apsp_checker.sv
// Port-level checks for the shortest path router, bound to the top level.
`timescale 1ns / 1ps
module apsp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [15:0]                 link_cost_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [apsp_pkg::NODE_W-1:0] source_node_o,
  input logic [apsp_pkg::NODE_W-1:0] dest_node_o,
  input logic [15:0]                 path_cost_o,
  input logic [apsp_pkg::NODE_W-1:0] next_hop_o,
  input logic                        last_entry_o
);
  import apsp_pkg::*;

  // a stalled cost transaction stays offered with its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(link_cost_i))
    else $error("stalled cost changed");

  // a stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // and its payload does not move
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(path_cost_o) && $stable(next_hop_o)
      && $stable(source_node_o) && $stable(dest_node_o) && $stable(last_entry_o))
    else $error("stalled result changed");

  // the table ends on the diagonal entry of the last router
  a_last_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_entry_o |-> source_node_o == dest_node_o)
    else $error("last entry is not on the diagonal");

  // no new costs are taken while a table is still being emitted
  a_emit_blocks_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_entry_o |-> in_stall_o)
    else $error("input taken during table emit");

endmodule

bind all_pairs_shortest_path_router_unit apsp_checker u_apsp_checker (.*);
